[sv/crs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants of the collision risk selector
// Field widths, register codes, reset values and the item record that
// travels from the classifier through the queue to the ranking stage.
// ----------------------------------------------------------------------------
package crs_pkg;

  // Field widths
  localparam int CLS_W  = 8;
  localparam int ID_W   = 32;
  localparam int RNG_W  = 16;
  localparam int BRG_W  = 15;
  localparam int SPD_W  = 16;
  localparam int SECT_W = 14;
  localparam int SUM_W  = 17;             // 4*S + 3*min(|bearing|, S)
  localparam int NUM_W  = RNG_W + SUM_W;  // score numerator
  localparam int DEN_W  = 17;             // 256 + speed
  localparam int PROD_W = NUM_W + DEN_W;  // cross products

  // Stream packing
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 10;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Queue between classifier and ranking stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Arithmetic constants
  localparam logic [SECT_W-1:0] SECTOR_FLOOR = 14'd64;
  localparam logic [DEN_W-1:0]  DEN_BIAS     = 17'd256;
  localparam logic [DEN_W-1:0]  DEN_ONE      = 17'd1;

  // Register reset values
  localparam logic [CLS_W-1:0]  RST_GREEN_CLASS = 8'd0;
  localparam logic [CLS_W-1:0]  RST_RED_CLASS   = 8'd0;
  localparam logic [RNG_W-1:0]  RST_STANDOFF    = 16'd512;
  localparam logic [RNG_W-1:0]  RST_RISK_RANGE  = 16'd2560;
  localparam logic [SECT_W-1:0] RST_SECTOR      = 14'd2880;
  localparam logic [SPD_W-1:0]  RST_MIN_SPEED   = 16'd51;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GREEN_CLASS = 3'd0,
    REG_RED_CLASS   = 3'd1,
    REG_STANDOFF    = 3'd2,
    REG_RISK_RANGE  = 3'd3,
    REG_SECTOR      = 3'd4,
    REG_MIN_SPEED   = 3'd5
  } crs_reg_t;

  // Configuration register set
  typedef struct packed {
    logic [CLS_W-1:0]  green_class;
    logic [CLS_W-1:0]  red_class;
    logic [RNG_W-1:0]  standoff;
    logic [RNG_W-1:0]  risk_range;
    logic [SECT_W-1:0] sector;
    logic [SPD_W-1:0]  min_speed;
  } crs_cfg_t;

  // Classified obstacle, ready for ranking
  typedef struct packed {
    logic              qual;   // takes part in the ranking
    logic              viol;   // buoy standoff violation
    logic              last;   // closes the frame
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [ID_W-1:0]   id;
    logic [RNG_W-1:0]  rng;
    logic [BRG_W-1:0]  brg;
    logic [SPD_W-1:0]  spd;
  } crs_item_t;

endpackage
`default_nettype wire

[sv/crs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crs_front: obstacle classifier
// Two-stage pipeline: qualify the obstacle and build the sector term, then
// form the score numerator and denominator and hand the item to the queue.
// ----------------------------------------------------------------------------
module crs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  crs_pkg::crs_cfg_t                 cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              confirmed,
  input  logic                              values_finite,
  input  logic [crs_pkg::CLS_W-1:0]         class_code,
  input  logic [crs_pkg::ID_W-1:0]          obstacle_id,
  input  logic [crs_pkg::RNG_W-1:0]         obs_range,
  input  logic signed [crs_pkg::BRG_W-1:0]  bearing,
  input  logic [crs_pkg::SPD_W-1:0]         speed,
  input  logic                              last,
  output crs_pkg::crs_item_t                item,
  output logic                              item_valid,
  input  logic                              item_ready
);
  import crs_pkg::*;

  logic              s1_valid;
  logic              s1_qual;
  logic              s1_viol;
  logic              s1_last;
  logic [SUM_W-1:0]  s1_sum;
  logic [ID_W-1:0]   s1_id;
  logic [RNG_W-1:0]  s1_rng;
  logic [BRG_W-1:0]  s1_brg;
  logic [SPD_W-1:0]  s1_spd;

  logic              s1_ready;
  logic              s2_ready;
  logic [BRG_W-1:0]  brg_u;
  logic [BRG_W-1:0]  mag;
  logic [SECT_W-1:0] sect_eff;
  logic [SECT_W-1:0] mag_cl;
  logic [SUM_W-1:0]  sum;
  logic              usable;
  logic              buoy;
  logic              viol;
  logic              in_sector;
  logic              moving;
  logic              near_static;
  logic              qual;
  logic [NUM_W-1:0]  prod;

  // Pipeline flow control
  assign s2_ready = !item_valid || item_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // Classify the incoming obstacle
  always_comb begin
    brg_u       = $unsigned(bearing);
    mag         = brg_u[BRG_W-1] ? (~brg_u + BRG_W'(1)) : brg_u;
    sect_eff    = (cfg.sector < SECTOR_FLOOR) ? SECTOR_FLOOR : cfg.sector;
    mag_cl      = (mag < {1'b0, sect_eff}) ? mag[SECT_W-1:0] : sect_eff;
    sum         = {1'b0, sect_eff, 2'b00} + {3'b000, mag_cl} + {2'b00, mag_cl, 1'b0};
    usable      = confirmed && values_finite && (obs_range != '0);
    buoy        = ((cfg.green_class != '0) && (class_code == cfg.green_class)) ||
                  ((cfg.red_class != '0) && (class_code == cfg.red_class));
    viol        = usable && buoy && (obs_range <= cfg.standoff);
    in_sector   = mag <= {1'b0, cfg.sector};
    moving      = speed >= cfg.min_speed;
    near_static = {obs_range, 1'b0} <= {1'b0, cfg.risk_range};
    qual        = viol || (usable && (obs_range <= cfg.risk_range) && in_sector &&
                  (moving || near_static));
  end

  // Score numerator of a generic risk
  assign prod = {{SUM_W{1'b0}}, s1_rng} * {{RNG_W{1'b0}}, s1_sum};

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        item_valid <= s1_valid;
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_qual <= qual;
      s1_viol <= viol;
      s1_last <= last;
      s1_sum  <= sum;
      s1_id   <= obstacle_id;
      s1_rng  <= obs_range;
      s1_brg  <= brg_u;
      s1_spd  <= speed;
    end
    if (s2_ready && s1_valid) begin
      item.qual <= s1_qual;
      item.viol <= s1_viol;
      item.last <= s1_last;
      item.num  <= s1_viol ? {{SUM_W{1'b0}}, s1_rng} : prod;
      item.den  <= s1_viol ? DEN_ONE : (DEN_BIAS + {1'b0, s1_spd});
      item.id   <= s1_id;
      item.rng  <= s1_rng;
      item.brg  <= s1_brg;
      item.spd  <= s1_spd;
    end
  end

endmodule
`default_nettype wire

[sv/crs_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crs_queue: item queue between classifier and ranking stage
// Short first-in first-out buffer of classified obstacles.
// ----------------------------------------------------------------------------
module crs_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  crs_pkg::crs_item_t    push_item,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output crs_pkg::crs_item_t    pop_item,
  output logic [crs_pkg::QAW:0] level
);
  import crs_pkg::*;

  crs_item_t        slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic             push;
  logic             pop;

  assign push_ready = level != (QAW+1)'(QDEPTH);
  assign pop_valid  = level != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        level <= level + (QAW+1)'(1);
      end else if (pop && !push) begin
        level <= level - (QAW+1)'(1);
      end
    end
  end

  // Store an incoming transfer
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

[sv/crs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crs_back: ranking stage
// Cross-multiplies each item's score against the frame's best, keeps the
// winner, and on the frame's last item loads the result register.
// ----------------------------------------------------------------------------
module crs_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  crs_pkg::crs_item_t                item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              risk_detected,
  output logic                              standoff_violation,
  output logic [crs_pkg::ID_W-1:0]          chosen_id,
  output logic [crs_pkg::RNG_W-1:0]         chosen_range,
  output logic signed [crs_pkg::BRG_W-1:0]  chosen_bearing,
  output logic [crs_pkg::SPD_W-1:0]         chosen_speed
);
  import crs_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DEC
  } back_state_t;

  back_state_t       state;
  crs_item_t         cur;
  logic [PROD_W-1:0] prod_new;
  logic [PROD_W-1:0] prod_best;
  logic              have_best;
  logic              best_viol;
  logic [NUM_W-1:0]  best_num;
  logic [DEN_W-1:0]  best_den;
  logic [ID_W-1:0]   best_id;
  logic [RNG_W-1:0]  best_rng;
  logic [BRG_W-1:0]  best_brg;
  logic [SPD_W-1:0]  best_spd;

  logic              out_free;
  logic              dec_done;
  logic              emit;
  logic              take;
  logic              nb_have;
  logic              nb_viol;
  logic [ID_W-1:0]   nb_id;
  logic [RNG_W-1:0]  nb_rng;
  logic [BRG_W-1:0]  nb_brg;
  logic [SPD_W-1:0]  nb_spd;

  // Decide whether the current item replaces the best one
  always_comb begin
    out_free   = !out_valid || out_ready;
    dec_done   = (state == B_DEC) && (!cur.last || out_free);
    emit       = dec_done && cur.last;
    item_ready = (state == B_IDLE) || dec_done;
    take       = cur.qual && (!have_best || (!best_viol && cur.viol) ||
                 ((best_viol == cur.viol) && (prod_new < prod_best)));
    nb_have    = have_best || take;
    nb_viol    = take ? cur.viol : best_viol;
    nb_id      = take ? cur.id   : best_id;
    nb_rng     = take ? cur.rng  : best_rng;
    nb_brg     = take ? cur.brg  : best_brg;
    nb_spd     = take ? cur.spd  : best_spd;
  end

  // Sequence load, multiply, decide; hold best and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= B_IDLE;
      have_best          <= 1'b0;
      best_viol          <= 1'b0;
      best_num           <= '0;
      best_den           <= '0;
      best_id            <= '0;
      best_rng           <= '0;
      best_brg           <= '0;
      best_spd           <= '0;
      out_valid          <= 1'b0;
      risk_detected      <= 1'b0;
      standoff_violation <= 1'b0;
      chosen_id          <= '0;
      chosen_range       <= '0;
      chosen_bearing     <= '0;
      chosen_speed       <= '0;
    end else begin
      // Raise valid on a new result, drop it once taken
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (item_valid) begin
            cur   <= item;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prod_new  <= {{DEN_W{1'b0}}, cur.num} * {{NUM_W{1'b0}}, best_den};
          prod_best <= {{DEN_W{1'b0}}, best_num} * {{NUM_W{1'b0}}, cur.den};
          state     <= B_DEC;
        end
        B_DEC: begin
          if (dec_done) begin
            if (cur.last) begin
              // emit the winner and clear the frame
              risk_detected      <= nb_have;
              standoff_violation <= nb_viol;
              chosen_id          <= nb_id;
              chosen_range       <= nb_rng;
              chosen_bearing     <= $signed(nb_brg);
              chosen_speed       <= nb_spd;
              have_best          <= 1'b0;
              best_viol          <= 1'b0;
              best_num           <= '0;
              best_den           <= '0;
              best_id            <= '0;
              best_rng           <= '0;
              best_brg           <= '0;
              best_spd           <= '0;
            end else if (take) begin
              have_best <= 1'b1;
              best_viol <= cur.viol;
              best_num  <= cur.num;
              best_den  <= cur.den;
              best_id   <= cur.id;
              best_rng  <= cur.rng;
              best_brg  <= cur.brg;
              best_spd  <= cur.spd;
            end
            if (item_valid) begin
              cur   <= item;
              state <= B_MUL;
            end else begin
              state <= B_IDLE;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/collision_risk_selector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// collision_risk_selector: most urgent collision risk of a frame
// Classifier, item queue and ranking stage; one result per frame.
// ----------------------------------------------------------------------------
// Obstacles enter one per transfer on the s_ side; the transfer with s_tlast
// high closes the frame, and one result transfer leaves on the m_ side for
// each frame. The classifier, a two-stage pipeline, feeds a four-entry queue
// and takes one obstacle per cycle unless it and the queue are full; the
// ranking stage works each obstacle in the B_MUL state (the two 33x17 cross
// products) and then the B_DEC state (compare and keep), and takes the next
// obstacle only once it has decided the current one. A frame's last obstacle
// waits in the ranking stage until the result register is empty or being
// taken. Configuration writes take effect at the next cycle and are meant
// for idle periods between frames.
module collision_risk_selector (
  input  logic                               clk,
  input  logic                               rst,
  // obstacle stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // id[31:0], range[47:32], bearing[62:48], speed[78:63], zero[79]
  input  logic [crs_pkg::IN_TDATA_W-1:0]     s_tdata,
  // confirmed[0], values_finite[1], class_code[9:2]
  input  logic [crs_pkg::IN_TUSER_W-1:0]     s_tuser,
  input  logic                               s_tlast,
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // chosen_id[31:0], chosen_range[47:32], chosen_bearing[62:48],
  // chosen_speed[78:63], zero[79]
  output logic [crs_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // risk_detected[0], standoff_violation[1]
  output logic [crs_pkg::OUT_TUSER_W-1:0]    m_tuser,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [crs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import crs_pkg::*;

  crs_cfg_t          cfg;
  crs_item_t         f_item;
  logic              f_valid;
  logic              f_ready;
  crs_item_t         q_item;
  logic              q_valid;
  logic              q_ready;
  logic [QAW:0]      q_level;
  logic              risk_detected;
  logic              standoff_violation;
  logic [ID_W-1:0]   chosen_id;
  logic [RNG_W-1:0]  chosen_range;
  logic signed [BRG_W-1:0] chosen_bearing;
  logic [SPD_W-1:0]  chosen_speed;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.green_class <= RST_GREEN_CLASS;
      cfg.red_class   <= RST_RED_CLASS;
      cfg.standoff    <= RST_STANDOFF;
      cfg.risk_range  <= RST_RISK_RANGE;
      cfg.sector      <= RST_SECTOR;
      cfg.min_speed   <= RST_MIN_SPEED;
    end else if (cfg_we) begin
      case (crs_reg_t'(cfg_index))
        REG_GREEN_CLASS: cfg.green_class <= cfg_data[CLS_W-1:0];
        REG_RED_CLASS:   cfg.red_class   <= cfg_data[CLS_W-1:0];
        REG_STANDOFF:    cfg.standoff    <= cfg_data[RNG_W-1:0];
        REG_RISK_RANGE:  cfg.risk_range  <= cfg_data[RNG_W-1:0];
        REG_SECTOR:      cfg.sector      <= cfg_data[SECT_W-1:0];
        REG_MIN_SPEED:   cfg.min_speed   <= cfg_data[SPD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Classify incoming obstacles
  crs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .confirmed     (s_tuser[0]),
    .values_finite (s_tuser[1]),
    .class_code    (s_tuser[9:2]),
    .obstacle_id   (s_tdata[31:0]),
    .obs_range     (s_tdata[47:32]),
    .bearing       ($signed(s_tdata[62:48])),
    .speed         (s_tdata[78:63]),
    .last          (s_tlast),
    .item          (f_item),
    .item_valid    (f_valid),
    .item_ready    (f_ready)
  );

  // Buffer classified items
  crs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item),
    .level      (q_level)
  );

  // Rank and emit
  crs_back u_back (
    .clk                (clk),
    .rst                (rst),
    .item_valid         (q_valid),
    .item_ready         (q_ready),
    .item               (q_item),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .risk_detected      (risk_detected),
    .standoff_violation (standoff_violation),
    .chosen_id          (chosen_id),
    .chosen_range       (chosen_range),
    .chosen_bearing     (chosen_bearing),
    .chosen_speed       (chosen_speed)
  );

  // Pack the result transfer
  assign m_tdata = {1'b0, chosen_speed, $unsigned(chosen_bearing), chosen_range, chosen_id};
  assign m_tuser = {standoff_violation, risk_detected};

`ifndef ASSERT_OFF
  // Input stalls only when the whole front and the queue are full
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (q_level == (QAW+1)'(QDEPTH)))
    else $error("input stalled while the queue has room");

  // A frame without a risk reports an all-zero result
  a_empty_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> ((m_tdata == '0) && !m_tuser[1]))
    else $error("result without risk carries nonzero fields");

  // A standoff violation is always a detected risk
  a_viol_is_risk: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tuser[0])
    else $error("standoff violation flagged without risk");

  // Queue level never exceeds its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= (QAW+1)'(QDEPTH))
    else $error("queue level beyond depth");
`endif

endmodule
`default_nettype wire
